// File: rtl/core/apu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants of the fixed-point Adam update engine.
// ----------------------------------------------------------------------------
package apu_pkg;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LEARNING_RATE = 3'd0,
        CFG_BETA_FIRST    = 3'd1,
        CFG_BETA_SECOND   = 3'd2,
        CFG_EPSILON       = 3'd3,
        CFG_DECAY_FACTOR  = 3'd4
    } t_cfg_index;

    localparam logic [31:0] RST_LEARNING_RATE = 32'd4294967;
    localparam logic [31:0] RST_BETA_FIRST    = 32'd3865470566;
    localparam logic [31:0] RST_BETA_SECOND   = 32'd4290672329;
    localparam logic [31:0] RST_EPSILON       = 32'd43;
    localparam logic [31:0] RST_DECAY_FACTOR  = 32'd0;

    // per-item fields that ride along the pipeline
    typedef struct packed {
        logic               act;
        logic               sat;
        logic               msign;
        logic [15:0]        addr;
        logic signed [31:0] param;
    } t_side;

    typedef struct packed {
        logic [63:0] mhat;
        t_side       side;
    } t_root_side;

    typedef struct packed {
        logic  cap;
        t_side side;
    } t_upd_side;

    typedef struct packed {
        logic [31:0] beta_first;
        logic [31:0] beta_second;
        logic [31:0] decay_factor;
    } t_mom_cfg;

    typedef struct packed {
        logic clearing;
        logic hazard;
    } t_mom_status;

endpackage

// File: rtl/core/apu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module apu_div #(
    parameter int unsigned DW = 33,
    parameter int unsigned QW = 64,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          c_valid [QW];
    logic [DW-1:0] c_rem   [QW];
    logic [QW-1:0] c_num   [QW];
    logic [QW-1:0] c_quo   [QW];
    logic [DW-1:0] c_den   [QW];
    logic [SW-1:0] c_side  [QW];

    logic          r_valid [QW];
    logic [DW-1:0] r_rem   [QW];
    logic [QW-1:0] r_num   [QW];
    logic [QW-1:0] r_quo   [QW];
    logic [DW-1:0] r_den   [QW];
    logic [SW-1:0] r_side  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] w_trial;
        logic        w_bit;

        if (k == 0) begin : g_first
            assign c_valid[k] = i_valid;
            assign c_rem[k]   = i_rem;
            assign c_num[k]   = i_num;
            assign c_quo[k]   = '0;
            assign c_den[k]   = i_den;
            assign c_side[k]  = i_side;
        end else begin : g_next
            assign c_valid[k] = r_valid[k-1];
            assign c_rem[k]   = r_rem[k-1];
            assign c_num[k]   = r_num[k-1];
            assign c_quo[k]   = r_quo[k-1];
            assign c_den[k]   = r_den[k-1];
            assign c_side[k]  = r_side[k-1];
        end

        assign w_trial = {c_rem[k], c_num[k][QW-1]};
        assign w_bit   = (w_trial >= {1'b0, c_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= c_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_bit ? DW'(w_trial - {1'b0, c_den[k]}) : w_trial[DW-1:0];
                r_num[k]  <= {c_num[k][QW-2:0], 1'b0};
                r_quo[k]  <= {c_quo[k][QW-2:0], w_bit};
                r_den[k]  <= c_den[k];
                r_side[k] <= c_side[k];
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: rtl/core/apu_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module apu_sqrt #(
    parameter int unsigned QW = 48,
    parameter int unsigned SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*QW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [QW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic            c_valid [QW];
    logic [QW:0]     c_rem   [QW];
    logic [2*QW-1:0] c_rad   [QW];
    logic [QW-1:0]   c_root  [QW];
    logic [SW-1:0]   c_side  [QW];

    logic            r_valid [QW];
    logic [QW:0]     r_rem   [QW];
    logic [2*QW-1:0] r_rad   [QW];
    logic [QW-1:0]   r_root  [QW];
    logic [SW-1:0]   r_side  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [QW+2:0] w_cur;
        logic [QW+2:0] w_trial;
        logic          w_bit;

        if (k == 0) begin : g_first
            assign c_valid[k] = i_valid;
            assign c_rem[k]   = '0;
            assign c_rad[k]   = i_rad;
            assign c_root[k]  = '0;
            assign c_side[k]  = i_side;
        end else begin : g_next
            assign c_valid[k] = r_valid[k-1];
            assign c_rem[k]   = r_rem[k-1];
            assign c_rad[k]   = r_rad[k-1];
            assign c_root[k]  = r_root[k-1];
            assign c_side[k]  = r_side[k-1];
        end

        assign w_cur   = {c_rem[k], c_rad[k][2*QW-1:2*QW-2]};
        assign w_trial = {1'b0, c_root[k], 2'b01};
        assign w_bit   = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= c_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_bit ? (QW+1)'(w_cur - w_trial) : w_cur[QW:0];
                r_rad[k]  <= {c_rad[k][2*QW-3:0], 2'b00};
                r_root[k] <= {c_root[k][QW-2:0], w_bit};
                r_side[k] <= c_side[k];
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_root  = r_root[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: rtl/core/apu_moment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_moment
// Moment stores and their read-modify-write pipeline: weight decay,
// first and second moment blend, write back, clearing pass after reset.
// ----------------------------------------------------------------------------
module apu_moment
    import apu_pkg::*;
#(
    parameter int unsigned NUM_ELEMENTS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_act,
    input  logic [15:0]        i_addr,
    input  logic signed [31:0] i_param,
    input  logic signed [31:0] i_grad,
    input  logic [32:0]        i_bc1,
    input  logic [32:0]        i_bc2,
    input  t_mom_cfg           i_cfg,
    output t_mom_status        o_status,
    output logic               o_valid,
    output t_side              o_side,
    output logic [31:0]        o_mabs,
    output logic [47:0]        o_v,
    output logic [32:0]        o_bc1,
    output logic [32:0]        o_bc2
);

    localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ELEMENTS - 1);

    logic [31:0] r_mem_m [NUM_ELEMENTS];
    logic [47:0] r_mem_v [NUM_ELEMENTS];

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_cnt;

    // stage a
    logic               r_a_valid;
    t_side              r_a_side;
    logic signed [31:0] r_a_grad;
    logic [32:0]        r_a_bc1, r_a_bc2;
    logic signed [31:0] r_a_m;
    logic [47:0]        r_a_v;
    // stage b
    logic               r_b_valid;
    t_side              r_b_side;
    logic [32:0]        r_b_bc1, r_b_bc2;
    logic signed [31:0] r_b_g;
    logic signed [31:0] r_b_m;
    logic [47:0]        r_b_v;
    // stage c
    logic               r_c_valid;
    t_side              r_c_side;
    logic [32:0]        r_c_bc1, r_c_bc2;
    logic signed [64:0] r_c_pm1;
    logic signed [65:0] r_c_pm2;
    logic [47:0]        r_c_g2;
    logic [63:0]        r_c_pv_lo;
    logic [47:0]        r_c_pv_hi;
    // stage d
    logic               r_d_valid;
    t_side              r_d_side;
    logic [32:0]        r_d_bc1, r_d_bc2;
    logic signed [31:0] r_d_m;
    logic [64:0]        r_d_pg_lo;
    logic [48:0]        r_d_pg_hi;
    logic [63:0]        r_d_pv_lo;
    logic [47:0]        r_d_pv_hi;
    // stage e
    logic               r_e_valid;
    t_side              r_e_side;
    logic [32:0]        r_e_bc1, r_e_bc2;
    logic [31:0]        r_e_mabs;
    logic [47:0]        r_e_v;

    logic signed [64:0] w_dprod;
    logic [33:0]        w_gsum;
    logic signed [31:0] w_g;
    logic               w_gsat;
    logic signed [64:0] w_pm1;
    logic [32:0]        w_wc1;
    logic signed [65:0] w_pm2;
    logic [31:0]        w_ag;
    logic [63:0]        w_sq;
    logic [63:0]        w_pv_lo;
    logic [47:0]        w_pv_hi;
    logic [65:0]        w_msum;
    logic [32:0]        w_wc2;
    logic [64:0]        w_pg_lo;
    logic [48:0]        w_pg_hi;
    logic [81:0]        w_vsum;
    logic [47:0]        w_vnew;
    logic [31:0]        w_mabs;
    logic               w_wr;
    logic [AW-1:0]      w_rd_idx;
    logic [AW-1:0]      w_wr_idx;

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_rd_idx = AW'(i_addr);
    assign w_wr_idx = AW'(r_d_side.addr);
    assign w_wr     = i_en & r_d_valid & r_d_side.act & ~r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem_m[r_clr_cnt] <= '0;
            r_mem_v[r_clr_cnt] <= '0;
        end else if (w_wr) begin
            r_mem_m[w_wr_idx] <= r_d_m;
            r_mem_v[w_wr_idx] <= w_vnew;
        end
        if (i_en) begin
            r_a_m <= r_mem_m[w_rd_idx];
            r_a_v <= r_mem_v[w_rd_idx];
        end
    end

    // weight decay on the gradient
    assign w_dprod = $signed({1'b0, i_cfg.decay_factor}) * r_a_side.param;
    assign w_gsum  = {{2{r_a_grad[31]}}, r_a_grad} + {w_dprod[64], w_dprod[64:32]};

    always_comb begin
        w_g    = w_gsum[31:0];
        w_gsat = 1'b0;
        if (w_gsum[33:31] != 3'b000 && w_gsum[33:31] != 3'b111) begin
            w_gsat = 1'b1;
            w_g    = w_gsum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    // moment products
    assign w_pm1   = $signed({1'b0, i_cfg.beta_first}) * r_b_m;
    assign w_wc1   = ONE_Q32 - {1'b0, i_cfg.beta_first};
    assign w_pm2   = $signed({1'b0, w_wc1}) * r_b_g;
    assign w_ag    = r_b_g[31] ? (~r_b_g + 32'd1) : r_b_g;
    assign w_sq    = w_ag * w_ag;
    assign w_pv_lo = r_b_v[31:0] * i_cfg.beta_second;
    assign w_pv_hi = r_b_v[47:32] * i_cfg.beta_second;

    assign w_msum  = {r_c_pm1[64], r_c_pm1} + r_c_pm2;
    assign w_wc2   = ONE_Q32 - {1'b0, i_cfg.beta_second};
    assign w_pg_lo = r_c_g2[31:0] * w_wc2;
    assign w_pg_hi = r_c_g2[47:32] * w_wc2;

    assign w_vsum = 82'(r_d_pv_lo) + 82'({r_d_pv_hi, 32'd0})
                  + 82'(r_d_pg_lo) + 82'({r_d_pg_hi, 32'd0});
    assign w_vnew = w_vsum[79:32];
    assign w_mabs = r_d_m[31] ? (~r_d_m + 32'd1) : r_d_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side.act   <= i_act;
            r_a_side.sat   <= 1'b0;
            r_a_side.msign <= 1'b0;
            r_a_side.addr  <= i_addr;
            r_a_side.param <= i_param;
            r_a_grad       <= i_grad;
            r_a_bc1        <= i_bc1;
            r_a_bc2        <= i_bc2;

            r_b_side.act   <= r_a_side.act;
            r_b_side.sat   <= w_gsat;
            r_b_side.msign <= r_a_side.msign;
            r_b_side.addr  <= r_a_side.addr;
            r_b_side.param <= r_a_side.param;
            r_b_bc1        <= r_a_bc1;
            r_b_bc2        <= r_a_bc2;
            r_b_g          <= w_g;
            r_b_m          <= r_a_m;
            r_b_v          <= r_a_v;

            r_c_side  <= r_b_side;
            r_c_bc1   <= r_b_bc1;
            r_c_bc2   <= r_b_bc2;
            r_c_pm1   <= w_pm1;
            r_c_pm2   <= w_pm2;
            r_c_g2    <= w_sq[63:16];
            r_c_pv_lo <= w_pv_lo;
            r_c_pv_hi <= w_pv_hi;

            r_d_side.act   <= r_c_side.act;
            r_d_side.sat   <= r_c_side.sat;
            r_d_side.msign <= w_msum[63];
            r_d_side.addr  <= r_c_side.addr;
            r_d_side.param <= r_c_side.param;
            r_d_bc1        <= r_c_bc1;
            r_d_bc2        <= r_c_bc2;
            r_d_m          <= w_msum[63:32];
            r_d_pg_lo      <= w_pg_lo;
            r_d_pg_hi      <= w_pg_hi;
            r_d_pv_lo      <= r_c_pv_lo;
            r_d_pv_hi      <= r_c_pv_hi;

            r_e_side <= r_d_side;
            r_e_bc1  <= r_d_bc1;
            r_e_bc2  <= r_d_bc2;
            r_e_mabs <= w_mabs;
            r_e_v    <= w_vnew;
        end
    end

    // an element still on its way to write back blocks a new read of it
    assign o_status.hazard =
        (r_a_valid & r_a_side.act & (r_a_side.addr == i_addr)) |
        (r_b_valid & r_b_side.act & (r_b_side.addr == i_addr)) |
        (r_c_valid & r_c_side.act & (r_c_side.addr == i_addr)) |
        (r_d_valid & r_d_side.act & (r_d_side.addr == i_addr));
    assign o_status.clearing = r_clr_busy;

    assign o_valid = r_e_valid;
    assign o_side  = r_e_side;
    assign o_mabs  = r_e_mabs;
    assign o_v     = r_e_v;
    assign o_bc1   = r_e_bc1;
    assign o_bc2   = r_e_bc2;

endmodule

// File: rtl/core/adam_parameter_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_parameter_update
// Fixed-point Adam update engine over a flat element space.
//
// Input channel i_valid/o_ready carries one item per handshake. A mode 0 item
// starts an optimizer step (beta powers advance) and returns nothing; a mode 1
// item carries address, parameter and gradient and returns one item on
// o_valid/i_ready with the address, the new parameter and a saturation flag.
// A mode 1 item passes the moment read-modify-write, the bias-correction
// dividers, the square root, the update product, the update divider and
// one output register. One item can enter per cycle; no item enters during
// the clearing pass, and a mode 1 item also waits while the pipeline holds
// or while an earlier item to the same address is still inside the 4-stage
// moment write-back window. After reset the moment stores are cleared one
// entry per cycle, during which o_ready stays low; configuration writes
// are taken at any time. When the receiver holds i_ready low with a result
// waiting, the whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module adam_parameter_update
    import apu_pkg::*;
#(
    parameter int unsigned NUM_ELEMENTS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [15:0]        i_element_address,
    input  logic signed [31:0] i_param_value,
    input  logic signed [31:0] i_grad_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_result_address,
    output logic signed [31:0] o_new_param,
    output logic               o_saturated
);

    logic [31:0] r_learning_rate, r_beta_first, r_beta_second, r_epsilon, r_decay_factor;
    logic [32:0] r_bp1, r_bp2;
    logic        r_step_started;

    logic        w_en;
    logic        w_acc, w_acc0, w_acc1, w_act;
    logic [64:0] w_pw1, w_pw2;
    logic [32:0] w_bc1, w_bc2;
    t_mom_cfg    w_mcfg;
    t_mom_status w_status;

    logic        w_m_valid;
    t_side       w_m_side;
    logic [31:0] w_m_mabs;
    logic [47:0] w_m_v;
    logic [32:0] w_m_bc1, w_m_bc2;

    logic        w_vover;
    logic [32:0] w_vrem;
    logic        w_dm_valid, w_dv_valid;
    logic [63:0] w_qm, w_qv;
    t_side       w_dm_side;
    logic        w_dv_over;
    t_root_side  w_rs_in, w_rs_out;
    logic [63:0] w_vhat;
    logic        w_sq_valid;
    logic [47:0] w_root;

    logic        r_g_valid, r_h_valid, r_i_valid;
    t_side       r_g_side, r_h_side, r_i_side;
    logic [48:0] r_g_den, r_h_den, r_i_den;
    logic [63:0] r_g_p0, r_g_p1;
    logic [95:0] r_h_num;
    logic        r_i_cap;
    logic [48:0] r_i_rem;
    logic [32:0] r_i_num;
    logic [95:0] w_num;
    logic        w_cap;
    t_upd_side   w_us_in, w_us_out;
    logic        w_du_valid;
    logic [32:0] w_qu;
    logic [33:0] w_upd;
    logic [34:0] w_np;
    logic [31:0] w_np_clip;
    logic        w_np_sat;

    logic        r_out_valid;
    logic [15:0] r_out_addr;
    logic [31:0] r_out_param;
    logic        r_out_sat;

    assign w_en   = ~r_out_valid | i_ready;
    assign o_ready = ~w_status.clearing & (~i_mode | (w_en & ~w_status.hazard));
    assign w_acc  = i_valid & o_ready;
    assign w_acc0 = w_acc & ~i_mode;
    assign w_acc1 = w_acc & i_mode;
    assign w_act  = r_step_started & (32'(i_element_address) < 32'(NUM_ELEMENTS));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= RST_LEARNING_RATE;
            r_beta_first    <= RST_BETA_FIRST;
            r_beta_second   <= RST_BETA_SECOND;
            r_epsilon       <= RST_EPSILON;
            r_decay_factor  <= RST_DECAY_FACTOR;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LEARNING_RATE: r_learning_rate <= i_cfg_data;
                CFG_BETA_FIRST:    r_beta_first    <= i_cfg_data;
                CFG_BETA_SECOND:   r_beta_second   <= i_cfg_data;
                CFG_EPSILON:       r_epsilon       <= i_cfg_data;
                CFG_DECAY_FACTOR:  r_decay_factor  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // beta powers advance on each step start
    assign w_pw1 = r_bp1 * r_beta_first;
    assign w_pw2 = r_bp2 * r_beta_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp1          <= ONE_Q32;
            r_bp2          <= ONE_Q32;
            r_step_started <= 1'b0;
        end else if (w_acc0) begin
            r_bp1          <= w_pw1[64:32];
            r_bp2          <= w_pw2[64:32];
            r_step_started <= 1'b1;
        end
    end

    // zero correction is taken as one
    assign w_bc1 = (r_bp1 == ONE_Q32) ? ONE_Q32 : ONE_Q32 - r_bp1;
    assign w_bc2 = (r_bp2 == ONE_Q32) ? ONE_Q32 : ONE_Q32 - r_bp2;

    assign w_mcfg.beta_first   = r_beta_first;
    assign w_mcfg.beta_second  = r_beta_second;
    assign w_mcfg.decay_factor = r_decay_factor;

    apu_moment #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) u_moment (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_acc1),
        .i_act    (w_act),
        .i_addr   (i_element_address),
        .i_param  (i_param_value),
        .i_grad   (i_grad_value),
        .i_bc1    (w_bc1),
        .i_bc2    (w_bc2),
        .i_cfg    (w_mcfg),
        .o_status (w_status),
        .o_valid  (w_m_valid),
        .o_side   (w_m_side),
        .o_mabs   (w_m_mabs),
        .o_v      (w_m_v),
        .o_bc1    (w_m_bc1),
        .o_bc2    (w_m_bc2)
    );

    // bias correction, first moment
    apu_div #(
        .DW(33),
        .QW(64),
        .SW($bits(t_side))
    ) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_m_valid),
        .i_rem   (33'd0),
        .i_num   ({w_m_mabs, 32'd0}),
        .i_den   (w_m_bc1),
        .i_side  (w_m_side),
        .o_valid (w_dm_valid),
        .o_quo   (w_qm),
        .o_side  (w_dm_side)
    );

    // bias correction, second moment; quotient past 64 bits clips
    assign w_vover = ({17'd0, w_m_v[47:32]} >= w_m_bc2);
    assign w_vrem  = w_vover ? 33'd0 : {17'd0, w_m_v[47:32]};

    apu_div #(
        .DW(33),
        .QW(64),
        .SW(1)
    ) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_m_valid),
        .i_rem   (w_vrem),
        .i_num   ({w_m_v[31:0], 32'd0}),
        .i_den   (w_m_bc2),
        .i_side  (w_vover),
        .o_valid (w_dv_valid),
        .o_quo   (w_qv),
        .o_side  (w_dv_over)
    );

    assign w_vhat = w_dv_over ? 64'hffff_ffff_ffff_ffff : w_qv;

    always_comb begin
        w_rs_in          = '0;
        w_rs_in.mhat     = w_qm;
        w_rs_in.side     = w_dm_side;
        w_rs_in.side.sat = w_dm_side.sat | w_dv_over;
    end

    apu_sqrt #(
        .QW(48),
        .SW($bits(t_root_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dm_valid),
        .i_rad   ({w_vhat, 32'd0}),
        .i_side  (w_rs_in),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_rs_out)
    );

    // numerator lr * m_hat, denominator root + eps
    assign w_num = 96'(r_g_p0) + 96'({r_g_p1, 32'd0});
    assign w_cap = (r_h_den == 49'd0) ? (r_h_num != 96'd0)
                                      : (r_h_num[95:33] >= 63'(r_h_den));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= w_sq_valid;
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_side <= w_rs_out.side;
            r_g_den  <= 49'(w_root) + 49'(r_epsilon);
            r_g_p0   <= w_rs_out.mhat[31:0] * r_learning_rate;
            r_g_p1   <= w_rs_out.mhat[63:32] * r_learning_rate;

            r_h_side <= r_g_side;
            r_h_den  <= r_g_den;
            r_h_num  <= w_num;

            r_i_side <= r_h_side;
            r_i_cap  <= w_cap;
            // a zero denominator is replaced by one before it reaches the divider
            r_i_den  <= (r_h_den == 49'd0) ? 49'd1 : r_h_den;
            r_i_rem  <= r_h_num[81:33];
            r_i_num  <= r_h_num[32:0];
        end
    end

    assign w_us_in.cap  = r_i_cap;
    assign w_us_in.side = r_i_side;

    apu_div #(
        .DW(49),
        .QW(33),
        .SW($bits(t_upd_side))
    ) u_div_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_i_valid),
        .i_rem   (w_us_in.cap ? 49'd0 : r_i_rem),
        .i_num   (r_i_num),
        .i_den   (r_i_den),
        .i_side  (w_us_in),
        .o_valid (w_du_valid),
        .o_quo   (w_qu),
        .o_side  (w_us_out)
    );

    // step is capped at 2^33
    assign w_upd = w_us_out.cap ? 34'h2_0000_0000 : {1'b0, w_qu};
    assign w_np  = w_us_out.side.msign
                 ? {{3{w_us_out.side.param[31]}}, w_us_out.side.param} + {1'b0, w_upd}
                 : {{3{w_us_out.side.param[31]}}, w_us_out.side.param} - {1'b0, w_upd};

    always_comb begin
        w_np_clip = w_np[31:0];
        w_np_sat  = 1'b0;
        if (w_np[34:31] != 4'b0000 && w_np[34:31] != 4'b1111) begin
            w_np_sat  = 1'b1;
            w_np_clip = w_np[34] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_du_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_addr <= w_us_out.side.addr;
            if (w_us_out.side.act) begin
                r_out_param <= w_np_clip;
                r_out_sat   <= w_us_out.side.sat | w_np_sat;
            end else begin
                r_out_param <= w_us_out.side.param;
                r_out_sat   <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_new_param      = r_out_param;
    assign o_saturated      = r_out_sat;

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !r_out_valid)
        else $error("result present during clearing pass");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp1 <= ONE_Q32) && (r_bp2 <= ONE_Q32))
        else $error("beta power above one");

    a_step_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc0 |=> r_step_started)
        else $error("step start not recorded");

    // both bias-correction dividers carry the same item
    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_valid == w_dm_valid)
        else $error("bias-correction dividers out of step");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point Adam update engine: directed rows,
// then four register settings with random items; results are checked against
// set values or an in-bench model of the moment stores and update arithmetic.
// ----------------------------------------------------------------------------
module tb;
    import apu_pkg::*;

    localparam logic        MODE_STEP   = 1'b0;
    localparam logic        MODE_UPDATE = 1'b1;
    localparam logic [2:0]  CFG_NONE    = 3'd7;
    localparam int          LATENCY     = 170;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [15:0]        addr;
        logic signed [31:0] param;
        logic               sat;
    } t_update;

    typedef struct {
        logic        mode;
        logic [15:0] addr;
        logic [31:0] param;
        logic [31:0] grad;
        logic        known;
        logic [31:0] exp_param;
        logic        exp_sat;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic [15:0]        i_element_address;
    logic signed [31:0] i_param_value;
    logic signed [31:0] i_grad_value;
    logic               o_valid;
    logic               i_ready;
    logic [15:0]        o_result_address;
    logic signed [31:0] o_new_param;
    logic               o_saturated;

    adam_parameter_update dut (.*);

    // model state
    logic [31:0] lr, beta1, beta2, eps, decay;
    logic [32:0] beta1_pow, beta2_pow;
    logic        step_on;
    int          first_m[int];
    logic [47:0] second_m[int];

    t_update pending_updates[$];
    int      errors;
    int      cycles;
    bit      calm;
    bit      hold_req;
    int      hold_left;
    int      stall_left;

    t_row directed[12] = '{
        '{MODE_UPDATE, 16'h0000, 32'h7FFFFFFF, 32'h80000000, 1'b1, 32'h7FFFFFFF, 1'b0},
        '{MODE_UPDATE, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1, 32'h80000000, 1'b0},
        '{MODE_UPDATE, 16'h1234, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{MODE_STEP,   16'h0000, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'h0000, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'h0001, 32'h80000000, 32'h80000000, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'h0000, 32'h01000000, 32'h80000000, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'h0000, 32'h01000000, 32'h80000000, 1'b0, 32'h0, 1'b0},
        '{MODE_STEP,   16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'h0002, 32'hFFFFFFFF, 32'h00000001, 1'b0, 32'h0, 1'b0},
        '{MODE_UPDATE, 16'hFFFF, 32'h00000000, 32'h80000000, 1'b0, 32'h0, 1'b0}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint clip32(input longint x, inout logic sat);
        if (x > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // floor(sqrt(x * 2^32)), bit-pair restoring method
    function automatic logic [63:0] root_q32(input logic [63:0] x);
        logic [127:0] radicand;
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        radicand = {32'b0, x, 32'b0};
        rem = '0;
        root = '0;
        for (int i = 47; i >= 0; i--) begin
            rem = (rem << 2) | radicand[2*i +: 2];
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    function automatic void adam_update(input logic mode, input logic [15:0] addr,
                                        input logic signed [31:0] param,
                                        input logic signed [31:0] grad,
                                        output logic has, output t_update u);
        longint       g, m, m_old, prod, np;
        logic [64:0]  pow_prod;
        logic [63:0]  ag, g2, bc1, bc2, am, mhat, vhat, den, upd;
        logic [95:0]  vnum;
        logic [47:0]  v_old;
        logic [127:0] num, q;
        logic         sat;
        has = 1'b0;
        u = '{default: '0};
        if (mode == MODE_STEP) begin
            pow_prod = beta1_pow * beta1;
            beta1_pow = pow_prod[64:32];
            pow_prod = beta2_pow * beta2;
            beta2_pow = pow_prod[64:32];
            step_on = 1'b1;
            return;
        end
        has = 1'b1;
        u.addr = addr;
        u.param = param;
        u.sat = 1'b0;
        if (!step_on) return;
        sat = 1'b0;
        prod = longint'(decay) * longint'(param);
        g = clip32(longint'(grad) + (prod >>> 32), sat);

        m_old = first_m.exists(addr) ? longint'(first_m[addr]) : 0;
        m = (longint'(beta1) * m_old + (longint'(ONE_Q32) - longint'(beta1)) * g) >>> 32;
        first_m[addr] = int'(m);

        ag = (g < 0) ? 64'(-g) : 64'(g);
        g2 = (ag * ag) >> 16;
        v_old = second_m.exists(addr) ? second_m[addr] : 48'd0;
        vnum = v_old * beta2 + g2 * (ONE_Q32 - beta2);
        second_m[addr] = vnum[79:32];

        bc1 = ONE_Q32 - beta1_pow;
        bc2 = ONE_Q32 - beta2_pow;
        if (bc1 == 0) bc1 = ONE_Q32;
        if (bc2 == 0) bc2 = ONE_Q32;

        // bias correction; only the second moment can overflow
        am = (m < 0) ? 64'(-m) : 64'(m);
        num = 128'(am) << 32;
        q = num / bc1;
        mhat = q[63:0];
        num = 128'(vnum[79:32]) << 32;
        q = num / bc2;
        if (q[127:64] != 0) begin
            vhat = '1;
            sat = 1'b1;
        end else begin
            vhat = q[63:0];
        end

        den = root_q32(vhat) + eps;
        num = 128'(mhat) * lr;
        if (den == 0) begin
            upd = (num != 0) ? '1 : '0;
        end else begin
            q = num / den;
            upd = (q[127:64] != 0) ? '1 : q[63:0];
        end
        if (upd > (64'd1 << 33)) upd = 64'd1 << 33;

        np = (m < 0) ? longint'(param) + longint'(upd) : longint'(param) - longint'(upd);
        np = clip32(np, sat);
        u.param = np[31:0];
        u.sat = sat;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3, 4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic mode, input logic [15:0] addr,
                             input logic [31:0] param, input logic [31:0] grad,
                             input logic known, input logic [31:0] exp_param,
                             input logic exp_sat);
        int      gap;
        logic    has;
        t_update u;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_element_address <= addr;
        i_param_value <= param;
        i_grad_value <= grad;
        do @(posedge i_clk); while (!o_ready);
        adam_update(mode, addr, param, grad, has, u);
        if (has) begin
            if (known) begin
                u.param = exp_param;
                u.sat = exp_sat;
            end
            pending_updates.push_back(u);
        end
    endtask

    task automatic write_regs(input logic [31:0] r_lr, input logic [31:0] r_b1,
                              input logic [31:0] r_b2, input logic [31:0] r_eps,
                              input logic [31:0] r_decay);
        logic [2:0]  idx[6];
        logic [31:0] val[6];
        idx = '{CFG_LEARNING_RATE, CFG_BETA_FIRST, CFG_BETA_SECOND, CFG_EPSILON,
                CFG_DECAY_FACTOR, CFG_NONE};
        val = '{r_lr, r_b1, r_b2, r_eps, r_decay, $urandom};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
            case (idx[i])
                CFG_LEARNING_RATE: lr = val[i];
                CFG_BETA_FIRST:    beta1 = val[i];
                CFG_BETA_SECOND:   beta2 = val[i];
                CFG_EPSILON:       eps = val[i];
                CFG_DECAY_FACTOR:  decay = val[i];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit pressure);
        logic        mode;
        logic [15:0] addr;
        for (int k = 0; k < count; k++) begin
            calm = (k % 200) < 40;
            if (pressure && k == 60) hold_req = 1'b1;
            mode = ($urandom_range(0, 24) == 0) ? MODE_STEP : MODE_UPDATE;
            // small address pool keeps same-address hazards frequent
            addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                        : 16'($urandom_range(0, 65535));
            send_item(mode, addr, rand_word(), rand_word(), 1'b0, '0, 1'b0);
        end
        i_valid <= 1'b0;
        calm = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic check_result();
        t_update exp_u;
        if (pending_updates.size() == 0) begin
            $error("result_address %h arrived with nothing expected", o_result_address);
            errors++;
            return;
        end
        exp_u = pending_updates.pop_front();
        if (o_result_address !== exp_u.addr) begin
            $error("result_address expected %h got %h", exp_u.addr, o_result_address);
            errors++;
        end
        if (o_new_param !== exp_u.param) begin
            $error("new_param expected %h got %h", exp_u.param, o_new_param);
            errors++;
        end
        if (o_saturated !== exp_u.sat) begin
            $error("saturated expected %b got %b", exp_u.sat, o_saturated);
            errors++;
        end
    endtask

    // result side: checking plus random and forced back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_result();
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            i_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LEARNING_RATE;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_mode = MODE_STEP;
        i_element_address = '0;
        i_param_value = '0;
        i_grad_value = '0;
        i_ready = 1'b1;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        lr = RST_LEARNING_RATE;
        beta1 = RST_BETA_FIRST;
        beta2 = RST_BETA_SECOND;
        eps = RST_EPSILON;
        decay = RST_DECAY_FACTOR;
        beta1_pow = ONE_Q32;
        beta2_pow = ONE_Q32;
        step_on = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: pass-through before the first step, then updates
        foreach (directed[i])
            send_item(directed[i].mode, directed[i].addr, directed[i].param,
                      directed[i].grad, directed[i].known, directed[i].exp_param,
                      directed[i].exp_sat);
        run_random(350, 1'b0);
        wait_idle();

        // extremes: full step, betas zero, no epsilon, full decay
        write_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        run_random(350, 1'b1);
        wait_idle();

        // betas at max keep the bias correction tiny
        write_regs($urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        run_random(400, 1'b0);
        wait_idle();

        write_regs($urandom_range(0, 32'h00FF_FFFF), $urandom, $urandom,
                   $urandom_range(0, 1000), $urandom);
        run_random(450, 1'b0);
        wait_idle();

        if (pending_updates.size() != 0) begin
            $error("%0d expected results never arrived", pending_updates.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: adam_parameter_update.f
rtl/core/apu_pkg.sv
rtl/core/apu_div.sv
rtl/core/apu_sqrt.sv
rtl/core/apu_moment.sv
rtl/core/adam_parameter_update.sv
tb/tb.sv
